// ===== design/bmpep_pkg.sv =====
// Shared types, constants and color mapping for the BMP to six-color packer.
// No dependencies.
package bmpep_pkg;

   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;

   localparam int unsigned WidthBits  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HeightBits = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned HalfBits   = WidthBits - 1;
   localparam int unsigned ProdBits   = HalfBits + HeightBits;

   localparam int unsigned FbAddrBits = 19;
   localparam int unsigned FbDataBits = 8;
   localparam int unsigned ColorBits  = 3;

   // parse phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SKIP   = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;
   localparam logic [1:0] PH_PAD    = 2'd3;

   // color channels of one pixel in file order
   localparam logic [1:0] CH_BLUE  = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_RED   = 2'd2;

   // header byte positions at which a field is complete
   localparam logic [15:0] HDR_SIGNATURE = 16'd1;
   localparam logic [15:0] HDR_OFFSET    = 16'd13;
   localparam logic [15:0] HDR_WIDTH     = 16'd21;
   localparam logic [15:0] HDR_HEIGHT    = 16'd25;
   localparam logic [15:0] HDR_DEPTH     = 16'd29;
   localparam logic [15:0] HDR_LAST      = 16'd53;
   localparam logic [15:0] HDR_SIZE      = 16'd54;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [15:0] BMP_DEPTH     = 16'd24;

   localparam logic [ColorBits-1:0] COLOR_BLACK  = 3'd0;
   localparam logic [ColorBits-1:0] COLOR_WHITE  = 3'd1;
   localparam logic [ColorBits-1:0] COLOR_YELLOW = 3'd2;
   localparam logic [ColorBits-1:0] COLOR_RED    = 3'd3;
   localparam logic [ColorBits-1:0] COLOR_BLUE   = 3'd5;
   localparam logic [ColorBits-1:0] COLOR_GREEN  = 3'd6;

   typedef struct packed {
      logic                  status;
      logic [FbAddrBits-1:0] fb_address;
      logic [FbDataBits-1:0] fb_data;
      logic                  last_write;
   } rsp_type;

   function automatic logic [ColorBits-1:0] map_color(input logic [7:0] b,
                                                      input logic [7:0] g,
                                                      input logic [7:0] r);
      logic [ColorBits-1:0] c;
      priority if (b == 8'h00 && g == 8'h00 && r == 8'h00) c = COLOR_BLACK;
      else if (b == 8'hFF && g == 8'hFF && r == 8'hFF) c = COLOR_WHITE;
      else if (b == 8'h00 && g == 8'hFF && r == 8'hFF) c = COLOR_YELLOW;
      else if (b == 8'h00 && g == 8'h00 && r == 8'hFF) c = COLOR_RED;
      else if (b == 8'hFF && g == 8'h00 && r == 8'h00) c = COLOR_BLUE;
      else if (b == 8'h00 && g == 8'hFF && r == 8'h00) c = COLOR_GREEN;
      else c = COLOR_WHITE;
      return c;
   endfunction

endpackage

// ===== design/bmp_to_epaper_six_color_packer.sv =====
// Top level of the 24-bit BMP to six-color e-paper frame buffer packer.
// Depends on bmpep_pkg.

// Takes one BMP file byte per cycle on req_ (no stall of its own unless two
// results are backed up) and gives zero or one frame buffer write per byte on
// rsp_, where each result is registered first. The first 54 bytes are the
// header; on its last byte a bad header gives one result with rsp_status high
// and the parser starts over on the next byte. Bytes up to the data offset are
// dropped, row padding is dropped, and every second pixel of a row gives one
// write of two 4-bit color indices. The address path (one row index times half
// the width, plus the column half) sets the clock, with the color compare
// beside it. A two-entry result register/skid pair keeps input flowing while
// rsp_stall holds a result; csr_ writes are taken at any time and apply to the
// next write.
module bmp_to_epaper_six_color_packer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_file_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic [bmpep_pkg::FbAddrBits-1:0]  rsp_fb_address,
   output logic [bmpep_pkg::FbDataBits-1:0]  rsp_fb_data,
   output logic                              rsp_last_write,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_rotate_half_turn
);

   localparam int unsigned WB = bmpep_pkg::WidthBits;
   localparam int unsigned HB = bmpep_pkg::HeightBits;
   localparam int unsigned XB = bmpep_pkg::HalfBits;
   localparam int unsigned PB = bmpep_pkg::ProdBits;
   localparam int unsigned AB = bmpep_pkg::FbAddrBits;
   localparam int unsigned CB = bmpep_pkg::ColorBits;

   logic          rotate_ff;
   logic [1:0]    phase_ff, phase_in;
   logic [15:0]   byte_count_ff, byte_count_in;
   logic [23:0]   asm_ff, asm_in;
   logic          sig_ok_ff, sig_ok_in;
   logic [15:0]   offset_ff, offset_in;
   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic          depth_ok_ff, depth_ok_in;
   logic [WB-1:0] col_ff, col_in;
   logic [HB-1:0] row_ff, row_in;
   logic [1:0]    chan_ff, chan_in;
   logic [7:0]    blue_ff, blue_in;
   logic [7:0]    green_ff, green_in;
   logic [CB-1:0] held_color_ff, held_color_in;
   logic [1:0]    pad_ff, pad_in;

   logic                 out_valid_ff;
   bmpep_pkg::rsp_type   out_ff;
   logic                 skid_valid_ff;
   bmpep_pkg::rsp_type   skid_ff;

   logic                 accept;
   logic                 produce;
   bmpep_pkg::rsp_type   result;

   logic [31:0]   word;
   logic [15:0]   byte_count_inc;
   logic [WB-1:0] col_inc;
   logic [HB-1:0] row_inc;
   logic [XB-1:0] half;
   logic [XB-1:0] xhalf;
   logic [HB-1:0] y;
   logic [PB-1:0] row_prod;
   logic [CB-1:0] color;
   logic          header_bad;
   logic          drain;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign drain     = out_valid_ff && !rsp_stall;

   assign word           = {req_file_byte, asm_ff};
   assign byte_count_inc = byte_count_ff + 16'd1;
   assign col_inc        = col_ff + WB'(1);
   assign row_inc        = row_ff + HB'(1);
   assign half           = width_ff[WB-1:1];
   assign color          = bmpep_pkg::map_color(blue_ff, green_ff, req_file_byte);

   assign header_bad = !sig_ok_ff || !depth_ok_ff || (offset_ff < bmpep_pkg::HDR_SIZE) ||
                       (width_ff == '0) || (height_ff == '0);

   // column half and row of the write, with or without the half turn
   always_comb begin
      if (rotate_ff) begin
         xhalf = half - XB'(1) - XB'(col_ff >> 1);
         y     = row_ff;
      end else begin
         xhalf = XB'(col_ff >> 1);
         y     = height_ff - HB'(1) - row_ff;
      end
   end

   assign row_prod = PB'(y) * PB'(half);

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      asm_in        = asm_ff;
      sig_ok_in     = sig_ok_ff;
      offset_in     = offset_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      depth_ok_in   = depth_ok_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      chan_in       = chan_ff;
      blue_in       = blue_ff;
      green_in      = green_ff;
      held_color_in = held_color_ff;
      pad_in        = pad_ff;
      produce       = 1'b0;
      result        = '0;

      if (accept) begin
         unique case (phase_ff)
            bmpep_pkg::PH_HEADER: begin
               asm_in = word[31:8];
               unique case (byte_count_ff)
                  bmpep_pkg::HDR_SIGNATURE:
                     sig_ok_in = (word[31:16] == bmpep_pkg::BMP_SIGNATURE);
                  bmpep_pkg::HDR_OFFSET:
                     offset_in = (word >= 32'd54 && word <= 32'd65535) ? word[15:0] : '0;
                  bmpep_pkg::HDR_WIDTH:
                     width_in = (word != '0 && !word[0] &&
                                 word <= 32'(bmpep_pkg::MAX_WIDTH)) ? WB'(word) : '0;
                  bmpep_pkg::HDR_HEIGHT:
                     height_in = (word != '0 &&
                                  word <= 32'(bmpep_pkg::MAX_HEIGHT)) ? HB'(word) : '0;
                  bmpep_pkg::HDR_DEPTH:
                     depth_ok_in = (word[31:16] == bmpep_pkg::BMP_DEPTH);
                  default: ;
               endcase
               if (byte_count_ff != bmpep_pkg::HDR_LAST) begin
                  byte_count_in = byte_count_inc;
               end else if (header_bad) begin
                  // reject and start over on the next byte
                  produce       = 1'b1;
                  result.status = 1'b1;
                  byte_count_in = '0;
               end else begin
                  byte_count_in = bmpep_pkg::HDR_SIZE;
                  col_in        = '0;
                  row_in        = '0;
                  chan_in       = bmpep_pkg::CH_BLUE;
                  phase_in      = (offset_ff == bmpep_pkg::HDR_SIZE) ?
                                  bmpep_pkg::PH_PIXELS : bmpep_pkg::PH_SKIP;
               end
            end
            bmpep_pkg::PH_SKIP: begin
               byte_count_in = byte_count_inc;
               if (byte_count_inc >= offset_ff) phase_in = bmpep_pkg::PH_PIXELS;
            end
            bmpep_pkg::PH_PAD: begin
               if (pad_ff > 2'd1) begin
                  pad_in = pad_ff - 2'd1;
               end else begin
                  pad_in = '0;
                  col_in = '0;
                  row_in = row_inc;
                  if (row_inc == height_ff) begin
                     phase_in      = bmpep_pkg::PH_HEADER;
                     byte_count_in = '0;
                  end else begin
                     phase_in = bmpep_pkg::PH_PIXELS;
                  end
               end
            end
            bmpep_pkg::PH_PIXELS: begin
               unique case (chan_ff)
                  bmpep_pkg::CH_BLUE: begin
                     blue_in = req_file_byte;
                     chan_in = bmpep_pkg::CH_GREEN;
                  end
                  bmpep_pkg::CH_GREEN: begin
                     green_in = req_file_byte;
                     chan_in  = bmpep_pkg::CH_RED;
                  end
                  default: begin
                     chan_in = bmpep_pkg::CH_BLUE;
                     if (!col_ff[0]) begin
                        held_color_in = color;
                     end else begin
                        produce           = 1'b1;
                        result.fb_address = AB'(row_prod) + AB'(xhalf);
                        result.fb_data    = rotate_ff ? {1'b0, color, 1'b0, held_color_ff}
                                                      : {1'b0, held_color_ff, 1'b0, color};
                        result.last_write = (row_inc == height_ff) && (col_inc == width_ff);
                     end
                     col_in = col_inc;
                     if (col_inc == width_ff) begin
                        if (width_ff[1:0] != 2'd0) begin
                           pad_in   = width_ff[1:0];
                           phase_in = bmpep_pkg::PH_PAD;
                        end else begin
                           col_in = '0;
                           row_in = row_inc;
                           if (row_inc == height_ff) begin
                              phase_in      = bmpep_pkg::PH_HEADER;
                              byte_count_in = '0;
                           end
                        end
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ff     <= 1'b1;
         phase_ff      <= bmpep_pkg::PH_HEADER;
         byte_count_ff <= '0;
         asm_ff        <= '0;
         sig_ok_ff     <= 1'b0;
         offset_ff     <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         depth_ok_ff   <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         chan_ff       <= bmpep_pkg::CH_BLUE;
         blue_ff       <= '0;
         green_ff      <= '0;
         held_color_ff <= '0;
         pad_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) rotate_ff <= csr_rotate_half_turn;
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         asm_ff        <= asm_in;
         sig_ok_ff     <= sig_ok_in;
         offset_ff     <= offset_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         depth_ok_ff   <= depth_ok_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         chan_ff       <= chan_in;
         blue_ff       <= blue_in;
         green_ff      <= green_in;
         held_color_ff <= held_color_in;
         pad_ff        <= pad_in;
      end
   end

   // result register with a skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || drain) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= produce;
         end
      end else if (produce) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || drain) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (produce) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_fb_address = out_ff.fb_address;
   assign rsp_fb_data    = out_ff.fb_data;
   assign rsp_last_write = out_ff.last_write;

endmodule

// ===== tb/tb_bmp_to_epaper_six_color_packer.sv =====
// Self-checking testbench for the BMP to six-color e-paper frame buffer packer.
// Streams whole BMP files byte by byte, predicts every frame buffer write and
// header rejection, and checks them in order. Depends on bmpep_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_bmp_to_epaper_six_color_packer;

   localparam int unsigned WB = bmpep_pkg::WidthBits;
   localparam int unsigned HB = bmpep_pkg::HeightBits;
   localparam int unsigned CB = bmpep_pkg::ColorBits;
   localparam int unsigned AB = bmpep_pkg::FbAddrBits;
   localparam int unsigned DB = bmpep_pkg::FbDataBits;

   localparam logic STATUS_WRITE  = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;
   localparam logic ROTATE_RESET  = 1'b1;

   localparam int unsigned RANDOM_BYTES  = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT   = 5_000_000;

   typedef enum int unsigned {
      DEFECT_NONE,
      DEFECT_SIGNATURE,
      DEFECT_DEPTH,
      DEFECT_OFFSET_LOW,
      DEFECT_OFFSET_HIGH,
      DEFECT_WIDTH_ZERO,
      DEFECT_WIDTH_ODD,
      DEFECT_WIDTH_WIDE,
      DEFECT_HEIGHT_ZERO,
      DEFECT_HEIGHT_TALL,
      DEFECT_HEIGHT_FLIPPED
   } hdr_defect_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_file_byte = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_status;
   logic [AB-1:0] rsp_fb_address;
   logic [DB-1:0] rsp_fb_data;
   logic          rsp_last_write;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_rotate_half_turn = 1'b0;

   bmp_to_epaper_six_color_packer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_file_byte        (req_file_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_fb_address       (rsp_fb_address),
      .rsp_fb_data          (rsp_fb_data),
      .rsp_last_write       (rsp_last_write),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_rotate_half_turn (csr_rotate_half_turn)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and expectations
   logic [7:0]          file_build[$];
   logic [7:0]          bmp_stream[$];
   bmpep_pkg::rsp_type  fb_writes_due[$];
   int unsigned bytes_queued = 0;
   int unsigned bytes_taken = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned tx_hold = 0;
   int unsigned rx_hold = 0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;

   // parser mirror
   logic          rot_cfg;
   logic [1:0]    stage;
   logic [15:0]   hdr_index;
   logic [31:0]   hdr_word;
   logic          sig_good;
   logic          depth_good;
   logic [15:0]   pix_offset;
   logic [WB-1:0] img_w;
   logic [HB-1:0] img_h;
   logic [WB-1:0] col_pos;
   logic [HB-1:0] row_pos;
   logic [1:0]    chan;
   logic [7:0]    blue_b;
   logic [7:0]    green_b;
   logic [CB-1:0] even_color;
   logic [1:0]    pad_left;

   task automatic clear_parser();
      stage      = bmpep_pkg::PH_HEADER;
      hdr_index  = '0;
      hdr_word   = '0;
      sig_good   = 1'b0;
      depth_good = 1'b0;
      pix_offset = '0;
      img_w      = '0;
      img_h      = '0;
      col_pos    = '0;
      row_pos    = '0;
      chan       = bmpep_pkg::CH_BLUE;
      blue_b     = '0;
      green_b    = '0;
      even_color = '0;
      pad_left   = '0;
   endtask

   task automatic finish_row();
      col_pos = '0;
      row_pos = row_pos + HB'(1);
      if (row_pos >= img_h) begin
         clear_parser();
      end else begin
         stage = bmpep_pkg::PH_PIXELS;
      end
   endtask

   function automatic logic [CB-1:0] palette_index(input logic [7:0] b,
                                                   input logic [7:0] g,
                                                   input logic [7:0] r);
      unique case ({r, g, b})
         24'h000000: return bmpep_pkg::COLOR_BLACK;
         24'hFFFFFF: return bmpep_pkg::COLOR_WHITE;
         24'hFFFF00: return bmpep_pkg::COLOR_YELLOW;
         24'hFF0000: return bmpep_pkg::COLOR_RED;
         24'h0000FF: return bmpep_pkg::COLOR_BLUE;
         24'h00FF00: return bmpep_pkg::COLOR_GREEN;
         default:    return bmpep_pkg::COLOR_WHITE;
      endcase
   endfunction

   // Advance the parser mirror by one file byte; queue any write it yields.
   task automatic parse_file_byte(input logic [7:0] fbyte);
      logic [31:0]        word;
      logic [CB-1:0]      shade;
      int unsigned        half;
      int unsigned        xh;
      int unsigned        yrow;
      int unsigned        addr_sum;
      bmpep_pkg::rsp_type wr;
      unique case (stage)
         bmpep_pkg::PH_HEADER: begin
            hdr_word = {fbyte, hdr_word[31:8]};
            word = hdr_word;
            unique case (hdr_index)
               bmpep_pkg::HDR_SIGNATURE:
                  sig_good = (word[31:16] == bmpep_pkg::BMP_SIGNATURE);
               bmpep_pkg::HDR_OFFSET:
                  pix_offset = (word >= {16'd0, bmpep_pkg::HDR_SIZE} &&
                                word <= 32'hFFFF) ? word[15:0] : '0;
               bmpep_pkg::HDR_WIDTH:
                  img_w = (word != 0 && !word[0] && word <= bmpep_pkg::MAX_WIDTH) ?
                          word[WB-1:0] : '0;
               bmpep_pkg::HDR_HEIGHT:
                  img_h = (word != 0 && word <= bmpep_pkg::MAX_HEIGHT) ?
                          word[HB-1:0] : '0;
               bmpep_pkg::HDR_DEPTH:
                  depth_good = (word[31:16] == bmpep_pkg::BMP_DEPTH);
               default: ;
            endcase
            if (hdr_index < bmpep_pkg::HDR_LAST) begin
               hdr_index = hdr_index + 16'd1;
            end else if (!sig_good || !depth_good || pix_offset < bmpep_pkg::HDR_SIZE ||
                         img_w == 0 || img_h == 0) begin
               clear_parser();
               wr.status     = STATUS_REJECT;
               wr.fb_address = '0;
               wr.fb_data    = '0;
               wr.last_write = 1'b0;
               fb_writes_due.push_back(wr);
            end else begin
               hdr_index = bmpep_pkg::HDR_SIZE;
               col_pos   = '0;
               row_pos   = '0;
               chan      = bmpep_pkg::CH_BLUE;
               stage     = (pix_offset == bmpep_pkg::HDR_SIZE) ?
                           bmpep_pkg::PH_PIXELS : bmpep_pkg::PH_SKIP;
            end
         end
         bmpep_pkg::PH_SKIP: begin
            hdr_index = hdr_index + 16'd1;
            if (hdr_index >= pix_offset) stage = bmpep_pkg::PH_PIXELS;
         end
         bmpep_pkg::PH_PAD: begin
            if (pad_left > 2'd1) begin
               pad_left = pad_left - 2'd1;
            end else begin
               pad_left = '0;
               finish_row();
            end
         end
         default: begin
            unique case (chan)
               bmpep_pkg::CH_BLUE: begin
                  blue_b = fbyte;
                  chan   = bmpep_pkg::CH_GREEN;
               end
               bmpep_pkg::CH_GREEN: begin
                  green_b = fbyte;
                  chan    = bmpep_pkg::CH_RED;
               end
               default: begin
                  chan  = bmpep_pkg::CH_BLUE;
                  shade = palette_index(blue_b, green_b, fbyte);
                  if (!col_pos[0]) begin
                     even_color = shade;
                  end else begin
                     half = img_w >> 1;
                     if (rot_cfg) begin
                        xh   = half - 1 - (col_pos >> 1);
                        yrow = row_pos;
                        wr.fb_data = {1'b0, shade, 1'b0, even_color};
                     end else begin
                        xh   = col_pos >> 1;
                        yrow = img_h - 1 - row_pos;
                        wr.fb_data = {1'b0, even_color, 1'b0, shade};
                     end
                     addr_sum      = xh + yrow * half;
                     wr.status     = STATUS_WRITE;
                     wr.fb_address = addr_sum[AB-1:0];
                     wr.last_write = (row_pos + 1 == img_h) && (col_pos + 1 == img_w);
                     fb_writes_due.push_back(wr);
                  end
                  col_pos = col_pos + WB'(1);
                  if (col_pos >= img_w) begin
                     if (img_w[1:0] != 2'd0) begin
                        pad_left = img_w[1:0];
                        stage    = bmpep_pkg::PH_PAD;
                     end else begin
                        finish_row();
                     end
                  end
               end
            endcase
         end
      endcase
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic check_write();
      bmpep_pkg::rsp_type want;
      if (fb_writes_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result status %0d addr %0h data %0h",
                                   rsp_status, rsp_fb_address, rsp_fb_data));
         return;
      end
      want = fb_writes_due.pop_front();
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
      if (rsp_fb_address !== want.fb_address)
         report_mismatch($sformatf("fb_address got %0h want %0h",
                                   rsp_fb_address, want.fb_address));
      if (rsp_fb_data !== want.fb_data)
         report_mismatch($sformatf("fb_data got %0h want %0h at addr %0h",
                                   rsp_fb_data, want.fb_data, want.fb_address));
      if (rsp_last_write !== want.last_write)
         report_mismatch($sformatf("last_write got %0d want %0d at addr %0h",
                                   rsp_last_write, want.last_write, want.fb_address));
   endtask

   function automatic int unsigned idle_span(input bit steady);
      int unsigned pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_file_byte <= '0;
         rot_cfg = ROTATE_RESET;
         clear_parser();
         fb_writes_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            parse_file_byte(req_file_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (tx_hold > 0) begin
               tx_hold--;
               req_valid <= 1'b0;
            end else if (bmp_stream.size() > 0) begin
               req_valid     <= 1'b1;
               req_file_byte <= bmp_stream.pop_front();
               tx_hold = idle_span(tx_steady);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_write();
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rx_hold = idle_span(rx_steady);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_bmp_to_epaper_six_color_packer NOT OK");
      $finish;
   end

   // {red, green, blue}, so little-endian staging gives file order
   function automatic logic [23:0] swatch(input int unsigned k);
      case (k)
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'hFFFF00;
         3: return 24'hFF0000;
         4: return 24'h0000FF;
         5: return 24'h00FF00;
         6: return 24'h00FFFF;
         default: return 24'h80FE7F;
      endcase
   endfunction

   function automatic logic [23:0] random_pixel();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return swatch($urandom_range(0, 5));
      if (pick < 85) return swatch($urandom_range(0, 5)) ^ (24'd1 << $urandom_range(0, 23));
      return 24'($urandom);
   endfunction

   task automatic stage_le(input logic [31:0] v, input int unsigned n);
      for (int k = 0; k < n; k++) file_build.push_back(v[8*k +: 8]);
   endtask

   task automatic build_file(input int unsigned w, input int unsigned h,
                             input int unsigned offs, input hdr_defect_type defect,
                             input bit ordered);
      logic [15:0] sig;
      logic [15:0] depth;
      logic [31:0] offs_f;
      logic [31:0] w_f;
      logic [31:0] h_f;
      int unsigned k;
      sig    = bmpep_pkg::BMP_SIGNATURE;
      depth  = bmpep_pkg::BMP_DEPTH;
      offs_f = offs;
      w_f    = w;
      h_f    = h;
      k      = 0;
      case (defect)
         DEFECT_SIGNATURE:
            sig = bmpep_pkg::BMP_SIGNATURE ^ (16'd1 << $urandom_range(0, 15));
         DEFECT_DEPTH:
            depth = bmpep_pkg::BMP_DEPTH ^ (16'd1 << $urandom_range(0, 15));
         DEFECT_OFFSET_LOW:
            offs_f = $urandom_range(0, bmpep_pkg::HDR_SIZE - 1);
         DEFECT_OFFSET_HIGH:
            offs_f = $urandom_range(0, 1) ? 32'h10000 : (32'h10000 | $urandom);
         DEFECT_WIDTH_ZERO: w_f = 0;
         DEFECT_WIDTH_ODD:  w_f = 2 * $urandom_range(0, bmpep_pkg::MAX_WIDTH / 2 - 1) + 1;
         DEFECT_WIDTH_WIDE: w_f = $urandom_range(0, 1) ? bmpep_pkg::MAX_WIDTH + 2 :
                                  {16'($urandom_range(1, 65535)), 16'd2};
         DEFECT_HEIGHT_ZERO: h_f = 0;
         DEFECT_HEIGHT_TALL: h_f = $urandom_range(0, 1) ? bmpep_pkg::MAX_HEIGHT + 1 :
                                   {16'($urandom_range(1, 65535)), 16'd1};
         DEFECT_HEIGHT_FLIPPED: h_f = 32'd0 - h;
         default: ;
      endcase
      stage_le({16'd0, sig}, 2);
      stage_le($urandom, 4);
      stage_le($urandom, 4);
      stage_le(offs_f, 4);
      stage_le($urandom, 4);
      stage_le(w_f, 4);
      stage_le(h_f, 4);
      stage_le($urandom, 2);
      stage_le({16'd0, depth}, 2);
      repeat (24) file_build.push_back(8'($urandom));
      if (defect == DEFECT_NONE) begin
         repeat (offs - bmpep_pkg::HDR_SIZE) file_build.push_back(8'($urandom));
         repeat (h) begin
            for (int c = 0; c < w; c++) begin
               stage_le({8'd0, ordered ? swatch(k % 8) : random_pixel()}, 3);
               k++;
            end
            repeat (w % 4) file_build.push_back(8'($urandom));
         end
      end
   endtask

   // Send up to limit staged bytes (all when zero), then hold until drained.
   task automatic run_phase(input int unsigned limit);
      int unsigned n;
      n = (limit == 0 || limit > file_build.size()) ? file_build.size() : limit;
      repeat (n) bmp_stream.push_back(file_build.pop_front());
      bytes_queued += n;
      while (bytes_taken != bytes_queued || fb_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rotation(input logic turn);
      @(posedge clock);
      csr_valid            <= 1'b1;
      csr_rotate_half_turn <= turn;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      rot_cfg = turn;
   endtask

   task automatic pick_idling();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      int unsigned random_bytes;
      int unsigned pick;
      int unsigned w;
      int unsigned h;
      int unsigned offs;
      random_bytes = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset rotation still in force
      pick_idling();
      build_file(2, 1, bmpep_pkg::HDR_SIZE, DEFECT_NONE, 1'b1);
      build_file(6, 2, bmpep_pkg::HDR_SIZE, DEFECT_NONE, 1'b1);
      build_file(2, 2, 60, DEFECT_NONE, 1'b0);
      run_phase(0);

      write_rotation(1'b0);
      pick_idling();
      build_file(6, 2, bmpep_pkg::HDR_SIZE, DEFECT_NONE, 1'b1);
      build_file(4, 3, 57, DEFECT_NONE, 1'b0);
      run_phase(0);

      // every header defect, then a good file to show the parser recovered
      pick_idling();
      for (int d = DEFECT_SIGNATURE; d <= DEFECT_HEIGHT_FLIPPED; d++)
         build_file(4, 2, bmpep_pkg::HDR_SIZE, hdr_defect_type'(d), 1'b0);
      build_file(2, 1, bmpep_pkg::HDR_SIZE, DEFECT_NONE, 1'b1);
      run_phase(0);

      // flip rotation mid-row, between an even pixel and its odd partner
      write_rotation(1'b1);
      pick_idling();
      build_file(4, 4, bmpep_pkg::HDR_SIZE, DEFECT_NONE, 1'b0);
      run_phase(bmpep_pkg::HDR_SIZE + 27);
      write_rotation(1'b0);
      run_phase(0);

      // mostly well-formed small files, some bad headers and raw noise
      while (random_bytes < RANDOM_BYTES) begin
         if ($urandom_range(0, 1)) write_rotation(1'($urandom_range(0, 1)));
         pick_idling();
         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               w = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(1, 16) :
                                                 2 * $urandom_range(1, 4);
               h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
               offs = $urandom_range(0, 1) ? bmpep_pkg::HDR_SIZE :
                                             bmpep_pkg::HDR_SIZE + $urandom_range(1, 10);
               build_file(w, h, offs, DEFECT_NONE, 1'b0);
            end else if (pick == 8) begin
               build_file(2 * $urandom_range(1, 4), $urandom_range(1, 4), bmpep_pkg::HDR_SIZE,
                          hdr_defect_type'($urandom_range(DEFECT_SIGNATURE,
                                                          DEFECT_HEIGHT_FLIPPED)), 1'b0);
            end else begin
               repeat (bmpep_pkg::HDR_SIZE) file_build.push_back(8'($urandom));
            end
         end
         random_bytes += file_build.size();
         run_phase(0);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fb_writes_due.size() != 0)
         report_mismatch($sformatf("%0d writes never arrived", fb_writes_due.size()));
      if (error_count == 0) begin
         $display("tb_bmp_to_epaper_six_color_packer OK");
      end else begin
         $display("tb_bmp_to_epaper_six_color_packer NOT OK");
      end
      $finish;
   end

endmodule

// ===== bmp_to_epaper_six_color_packer.f =====
design/bmpep_pkg.sv
design/bmp_to_epaper_six_color_packer.sv
tb/tb_bmp_to_epaper_six_color_packer.sv
